### rtl/core/hvd_pkg.sv
`default_nettype none

package hvd_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_BASE_LEVEL   = 2'd0;
	localparam logic [1:0] CFG_HEIGHT_GAIN  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

	// item modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_VERTEX = 1'b1;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// widest store address: 4096 x 4096 pixels
	localparam int ADDR_MAX_W = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [9:0]         base_level;
		logic signed [31:0] height_gain;
		logic [8:0]         image_width;
		logic [8:0]         image_height;
	} cfg_t;

	typedef struct packed {
		logic               mode;
		logic [15:0]        pixel_index;
		logic [23:0]        pixel_rgb;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
	} out_beat_t;

	// classified work item handed from front to back
	typedef struct packed {
		logic                  is_vtx;
		logic                  wr_ok;
		logic [ADDR_MAX_W-1:0] addr;
		logic [23:0]           rgb;
		logic signed [31:0]    pos_x;
		logic signed [31:0]    pos_y;
		logic signed [31:0]    pos_z;
		logic signed [15:0]    norm_x;
		logic signed [15:0]    norm_y;
		logic signed [15:0]    norm_z;
	} entry_t;

	// image size register limited to 1..maxv
	function automatic logic [8:0] limit_size(input logic [8:0] s, input int unsigned maxv);
		if (s == 9'd0)
			return 9'd1;
		if (32'(s) > maxv)
			return 9'(maxv);
		return s;
	endfunction

	// round Q2.14 x Q16.16 product to Q16.16 (ties up), add, saturate
	function automatic logic signed [31:0] round_sat(input logic signed [31:0] pos,
		input logic signed [58:0] p);
		logic signed [59:0] t;
		logic signed [45:0] q;
		logic signed [46:0] r;
		t = 60'(p) + 60'sd8192;
		q = 46'(t >>> 14);
		r = 47'(pos) + 47'(q);
		if (r > 47'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (r < -47'sd2147483648)
			return 32'sh8000_0000;
		return 32'(r);
	endfunction

endpackage

`default_nettype wire

### rtl/core/hvd_stream_if.sv
`default_nettype none

interface hvd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/hvd_front.sv
`default_nettype none

module hvd_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hvd_pkg::cfg_t  cfg,
	hvd_stream_if.sink     item,
	output hvd_pkg::entry_t entry,
	output logic           entry_valid,
	input  logic           entry_ready
);
	import hvd_pkg::*;

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic [8:0]  lim_w;
	logic [8:0]  lim_h;
	logic [16:0] u_clamp;
	logic [16:0] v_clamp;
	logic [25:0] pu;
	logic [25:0] pv;

	logic        v_s1;
	in_beat_t    beat_s1;
	logic [25:0] pu_s1;
	logic [25:0] pv_s1;

	logic [9:0]  w_last;
	logic [9:0]  h_last;
	logic [9:0]  col_raw;
	logic [9:0]  row_raw;
	logic [8:0]  col;
	logic [8:0]  row;
	logic [ADDR_MAX_W-1:0] vtx_addr;

	// clamp coordinates to one and scale by the image size
	always_comb begin
		lim_w   = limit_size(cfg.image_width, MAX_WIDTH);
		lim_h   = limit_size(cfg.image_height, MAX_HEIGHT);
		u_clamp = (item.data.tex_u > ONE_Q16) ? ONE_Q16 : item.data.tex_u;
		v_clamp = (item.data.tex_v > ONE_Q16) ? ONE_Q16 : item.data.tex_v;
		pu      = 26'(u_clamp) * 26'(lim_w);
		pv      = 26'(v_clamp) * 26'(lim_h);
	end

	assign item.ready = !v_s1 || entry_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready) begin
			beat_s1 <= item.data;
			pu_s1   <= pu;
			pv_s1   <= pv;
		end
	end

	// floor, clamp to last column and row, form the store address
	always_comb begin
		w_last   = {1'b0, lim_w} - 10'd1;
		h_last   = {1'b0, lim_h} - 10'd1;
		col_raw  = pu_s1[25:16];
		row_raw  = pv_s1[25:16];
		col      = (col_raw > w_last) ? w_last[8:0] : col_raw[8:0];
		row      = (row_raw > h_last) ? h_last[8:0] : row_raw[8:0];
		vtx_addr = ADDR_MAX_W'(32'(row) * 32'(MAX_WIDTH) + 32'(col));
	end

	// classify: loads write when in range, vertices read
	always_comb begin
		entry.is_vtx = (beat_s1.mode == MODE_VERTEX);
		entry.wr_ok  = (beat_s1.mode == MODE_LOAD) && (32'(beat_s1.pixel_index) < 32'(DEPTH));
		entry.addr   = (beat_s1.mode == MODE_VERTEX) ? vtx_addr
			: ADDR_MAX_W'(beat_s1.pixel_index);
		entry.rgb    = beat_s1.pixel_rgb;
		entry.pos_x  = beat_s1.pos_x;
		entry.pos_y  = beat_s1.pos_y;
		entry.pos_z  = beat_s1.pos_z;
		entry.norm_x = beat_s1.norm_x;
		entry.norm_y = beat_s1.norm_y;
		entry.norm_z = beat_s1.norm_z;
	end

	assign entry_valid = v_s1;

endmodule

`default_nettype wire

### rtl/core/hvd_queue.sv
`default_nettype none

module hvd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  hvd_pkg::entry_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output hvd_pkg::entry_t pop_data,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import hvd_pkg::*;

	entry_t                 slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

### rtl/core/hvd_back.sv
`default_nettype none

module hvd_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hvd_pkg::cfg_t   cfg,
	input  hvd_pkg::entry_t entry,
	input  logic            entry_valid,
	output logic            entry_ready,
	hvd_stream_if.source    result
);
	import hvd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [23:0] pixel_mem [DEPTH];

	logic en;
	logic take;

	logic v_b1, v_b2, v_b3, v_b4;
	entry_t e_b1, e_b2, e_b3;
	logic [23:0] px_b1;
	logic signed [42:0] dg_b2;
	logic signed [58:0] prod_x_b3, prod_y_b3, prod_z_b3;
	logic vtx_b4;
	out_beat_t res_b4;

	logic [9:0]         sum;
	logic signed [10:0] d;

	// whole back pipeline moves when the output register can move
	assign result.valid = v_b4 && vtx_b4;
	assign result.data  = res_b4;
	assign en           = !result.valid || result.ready;
	assign entry_ready  = en;
	assign take         = entry_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
		end else if (en) begin
			v_b1 <= entry_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
		end
	end

	// pixel store: load beats write, vertex beats read
	always_ff @(posedge clk) begin
		if (take) begin
			if (entry.wr_ok)
				pixel_mem[entry.addr[AW-1:0]] <= entry.rgb;
			px_b1 <= pixel_mem[entry.addr[AW-1:0]];
		end
	end

	// channel sum minus base level
	always_comb begin
		sum = 10'(px_b1[23:16]) + 10'(px_b1[15:8]) + 10'(px_b1[7:0]);
		d   = $signed({1'b0, sum}) - $signed({1'b0, cfg.base_level});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_b1      <= entry;
			e_b2      <= e_b1;
			dg_b2     <= 43'(d) * 43'(cfg.height_gain);
			e_b3      <= e_b2;
			prod_x_b3 <= 59'(e_b2.norm_x) * 59'(dg_b2);
			prod_y_b3 <= 59'(e_b2.norm_y) * 59'(dg_b2);
			prod_z_b3 <= 59'(e_b2.norm_z) * 59'(dg_b2);
			vtx_b4       <= e_b3.is_vtx;
			res_b4.new_x <= round_sat(e_b3.pos_x, prod_x_b3);
			res_b4.new_y <= round_sat(e_b3.pos_y, prod_y_b3);
			res_b4.new_z <= round_sat(e_b3.pos_z, prod_z_b3);
		end
	end

endmodule

`default_nettype wire

### rtl/core/heightmap_vertex_displace.sv
`default_nettype none

// Heightmap vertex displacement. Load beats (mode 0) write one packed RGB
// pixel into an on-chip store of MAX_WIDTH x MAX_HEIGHT entries at
// pixel_index; vertex beats (mode 1) look up the pixel under (u, v), take
// (r+g+b - base_level) * height_gain along the normal and return the
// saturated new position. The block accepts one beat per clock, loads and
// vertices mixed freely, as long as the output is not stalled; a vertex
// result passes through one front stage that scales the coordinates, a
// four-entry queue, the registered store read, the gain multiply, the
// normal multiply and the round-and-saturate output register. The queue
// lets input acceptance continue while a result waits. The store has no
// reset; entries read before being loaded return arbitrary data. The user
// writes configuration only while the block is idle; nothing enforces it.
module heightmap_vertex_displace #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	hvd_stream_if.sink  item,
	hvd_stream_if.source result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import hvd_pkg::*;

	cfg_t   cfg_q;
	entry_t f_entry;
	logic   f_valid;
	logic   f_ready;
	entry_t b_entry;
	logic   b_valid;
	logic   b_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_level   <= 10'd0;
			cfg_q.height_gain  <= 32'sd257;
			cfg_q.image_width  <= 9'd256;
			cfg_q.image_height <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE_LEVEL:   cfg_q.base_level   <= cfg_data[9:0];
				CFG_HEIGHT_GAIN:  cfg_q.height_gain  <= $signed(cfg_data);
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[8:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[8:0];
			endcase
		end
	end

	hvd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item        (item),
		.entry       (f_entry),
		.entry_valid (f_valid),
		.entry_ready (f_ready)
	);

	hvd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (f_entry),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_data   (b_entry),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	hvd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.entry       (b_entry),
		.entry_valid (b_valid),
		.entry_ready (b_ready),
		.result      (result)
	);

endmodule

`default_nettype wire
